// ===== hdl/grid_metric_coefficients_macros.svh =====
// assertion macros shared by the checker of the grid metric block
`ifndef GRID_METRIC_COEFFICIENTS_MACROS_SVH
`define GRID_METRIC_COEFFICIENTS_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GMC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gmc_pkg.sv =====
// types, constants and controller/datapath links of the grid metric block
package gmc_pkg;

    localparam int MAX_I_DEF = 64;
    localparam int MAX_J_DEF = 64;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;

    localparam logic REG_COUNT_I = 1'b0;
    localparam logic REG_COUNT_J = 1'b1;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam int NUM_SLOTS   = 5;
    localparam int NUM_METRICS = 5;
    localparam int DIV_STEPS   = 33;

    localparam logic [2:0] MET_KSI_X = 3'd0;
    localparam logic [2:0] MET_KSI_Y = 3'd1;
    localparam logic [2:0] MET_ETA_X = 3'd2;
    localparam logic [2:0] MET_ETA_Y = 3'd3;
    localparam logic [2:0] MET_INV_J = 3'd4;

    typedef struct packed {
        logic               op;
        logic        [5:0]  index_i;
        logic        [5:0]  index_j;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] ksi_x;
        logic signed [31:0] ksi_y;
        logic signed [31:0] eta_x;
        logic signed [31:0] eta_y;
        logic signed [31:0] inv_jacobian;
        logic               singular;
    } out_item_t;

    typedef struct packed {
        logic       store;
        logic       load;
        logic       rd_issue;
        logic [2:0] rd_slot;
        logic       cap;
        logic [2:0] cap_slot;
        logic       deriv;
        logic       mul_a;
        logic       mul_b;
        logic       prep;
        logic       div_init;
        logic       div_step;
        logic       div_end;
        logic [2:0] met;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic p_zero;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/gmc_ctrl.sv =====
// sequencing state machine of the grid metric block
module gmc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_op,
    output logic            in_stall,
    input  gmc_pkg::status_t status,
    output gmc_pkg::cmd_t    cmd
);
    import gmc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_DERIV = 10'b0000000100,
        S_MULA  = 10'b0000001000,
        S_MULB  = 10'b0000010000,
        S_PREP  = 10'b0000100000,
        S_DINIT = 10'b0001000000,
        S_DSTEP = 10'b0010000000,
        S_DEND  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] met_reg, met_next;
    logic [5:0] bit_reg, bit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            met_reg   <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            met_reg   <= met_next;
            bit_reg   <= bit_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        met_next   = met_reg;
        bit_next   = bit_reg;
        cmd        = '0;
        cmd.met    = met_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op == OP_STORE)
                    begin
                        cmd.store = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // issue slot cnt, capture the data of slot cnt-1
                cmd.rd_issue = (cnt_reg < 3'(NUM_SLOTS));
                cmd.rd_slot  = cnt_reg;
                cmd.cap      = (cnt_reg != 3'd0);
                cmd.cap_slot = cnt_reg - 3'd1;
                cnt_next     = cnt_reg + 3'd1;
                if (!status.in_range)
                begin
                    state_next = S_DONE;
                end
                else if (cnt_reg == 3'(NUM_SLOTS))
                begin
                    state_next = S_DERIV;
                end
            end
            S_DERIV:
            begin
                cmd.deriv  = 1'b1;
                state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                met_next = MET_KSI_X;
                if (status.p_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                bit_next     = '0;
                state_next   = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + 6'd1;
                if (bit_reg == 6'(DIV_STEPS - 1))
                begin
                    state_next = S_DEND;
                end
            end
            S_DEND:
            begin
                cmd.div_end = 1'b1;
                if (met_reg == MET_INV_J)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    met_next   = met_reg + 3'd1;
                    state_next = S_DINIT;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/gmc_datapath.sv =====
// coordinate memories, stencil, shared multiplier, divider and output register
module gmc_datapath #(
    parameter int MAX_I = gmc_pkg::MAX_I_DEF,
    parameter int MAX_J = gmc_pkg::MAX_J_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gmc_pkg::in_item_t            in_data,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [gmc_pkg::CFG_W-1:0]    cfg_data,
    input  gmc_pkg::cmd_t                cmd,
    output gmc_pkg::status_t             status,
    output logic                         out_valid,
    input  logic                         out_stall,
    output gmc_pkg::out_item_t           out_data
);
    import gmc_pkg::*;

    localparam int DEPTH = MAX_I * MAX_J;
    localparam int AW    = $clog2(DEPTH);
    localparam int LWI   = $clog2(MAX_I + 1);
    localparam int LWJ   = $clog2(MAX_J + 1);
    localparam int LW0   = (LWI > LWJ) ? LWI : LWJ;
    localparam int LW    = (LW0 > CFG_W) ? LW0 : CFG_W;
    localparam int DW    = 36;
    localparam int PW    = 72;
    localparam int RW    = 106;

    function automatic logic [LW-1:0] clamp(input logic [LW-1:0] c, input logic [LW-1:0] hi);
        logic [LW-1:0] r;
        begin
            r = c;
            if (c < LW'(3))
                r = LW'(3);
            else if (c > hi)
                r = hi;
            return r;
        end
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [5:0] i, input logic [5:0] j);
        begin
            return AW'(AW'(i) * AW'(MAX_J)) + AW'(j);
        end
    endfunction

    function automatic logic signed [DW-1:0] twice(
        input logic signed [31:0] c,
        input logic signed [31:0] p1,
        input logic signed [31:0] p2,
        input logic               first,
        input logic               last
    );
        logic signed [DW-1:0] ce, e1, e2, r;
        begin
            ce = DW'(c);
            e1 = DW'(p1);
            e2 = DW'(p2);
            if (first)
                r = (e1 <<< 2) - e2 - ((ce <<< 1) + ce);
            else if (last)
                r = ((ce <<< 1) + ce) - (e1 <<< 2) + e2;
            else
                r = e1 - e2;
            return r;
        end
    endfunction

    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] d);
        begin
            return d[DW-1] ? DW'(-d) : DW'(d);
        end
    endfunction

    function automatic logic [31:0] sat(input logic [32:0] q, input logic neg, input logic ovf);
        logic [31:0] r;
        begin
            if (!neg)
                r = (ovf || q > 33'h07FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
            else
                r = (ovf || q > 33'h080000000) ? 32'h80000000 : (~q[31:0] + 32'd1);
            return r;
        end
    endfunction

    logic [CFG_W-1:0] count_i_reg, count_j_reg;
    logic [LW-1:0]    ci, cj;

    logic [31:0] x_mem [DEPTH];
    logic [31:0] y_mem [DEPTH];
    logic signed [31:0] rdx_reg, rdy_reg;

    logic [5:0] qi_reg, qj_reg;
    logic       rng_reg, fi_reg, li_reg, fj_reg, lj_reg;
    logic       in_rng;
    logic [5:0] ri, rj;

    logic signed [31:0]   vx_reg [NUM_SLOTS];
    logic signed [31:0]   vy_reg [NUM_SLOTS];
    logic signed [DW-1:0] kx_reg, ky_reg, ex_reg, ey_reg;
    logic signed [DW-1:0] mul_x, mul_y;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] prod_a_reg, prod_b_reg;
    logic signed [PW:0]   p_full;
    logic [PW-1:0]        pmag_reg;
    logic                 pneg_reg;

    logic [RW-1:0]   num, rem_reg, dsh_reg;
    logic            nneg;
    logic            neg_reg, ovf_reg;
    logic [32:0]     quo_reg;
    logic [31:0]     res_reg [NUM_METRICS];
    logic            sing_reg;
    logic            out_valid_reg;
    out_item_t       out_data_reg;

    assign ci = clamp(LW'(count_i_reg), LW'(MAX_I));
    assign cj = clamp(LW'(count_j_reg), LW'(MAX_J));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_i_reg <= COUNT_RESET;
            count_j_reg <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_COUNT_I)
                count_i_reg <= cfg_data;
            else
                count_j_reg <= cfg_data;
        end
    end

    assign in_rng = (LW'(in_data.index_i) < ci) && (LW'(in_data.index_j) < cj);

    // stencil point of each read slot
    always_comb
    begin
        ri = qi_reg;
        rj = qj_reg;
        case (cmd.rd_slot)
            3'd1: ri = (fi_reg || !li_reg) ? qi_reg + 6'd1 : qi_reg - 6'd1;
            3'd2: ri = fi_reg ? qi_reg + 6'd2 : (li_reg ? qi_reg - 6'd2 : qi_reg - 6'd1);
            3'd3: rj = (fj_reg || !lj_reg) ? qj_reg + 6'd1 : qj_reg - 6'd1;
            3'd4: rj = fj_reg ? qj_reg + 6'd2 : (lj_reg ? qj_reg - 6'd2 : qj_reg - 6'd1);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && in_rng)
        begin
            x_mem[addr_of(in_data.index_i, in_data.index_j)] <= in_data.coord_x;
            y_mem[addr_of(in_data.index_i, in_data.index_j)] <= in_data.coord_y;
        end
        if (cmd.rd_issue)
        begin
            rdx_reg <= x_mem[addr_of(ri, rj)];
            rdy_reg <= y_mem[addr_of(ri, rj)];
        end
    end

    always_comb
    begin
        case (cmd.met)
            MET_KSI_X: begin num = RW'(mag(ey_reg)) << 33; nneg = ey_reg[DW-1];  end
            MET_KSI_Y: begin num = RW'(mag(ex_reg)) << 33; nneg = !ex_reg[DW-1]; end
            MET_ETA_X: begin num = RW'(mag(ky_reg)) << 33; nneg = !ky_reg[DW-1]; end
            MET_ETA_Y: begin num = RW'(mag(kx_reg)) << 33; nneg = kx_reg[DW-1];  end
            default:   begin num = RW'(1) << 50;           nneg = 1'b0;          end
        endcase
        // a zero magnitude gives zero whatever the sign
    end

    // one multiplier, operands picked by the step
    assign mul_x = cmd.mul_a ? kx_reg : ex_reg;
    assign mul_y = cmd.mul_a ? ey_reg : ky_reg;
    assign mul_p = PW'(mul_x) * PW'(mul_y);

    assign p_full = (PW+1)'(prod_a_reg) - (PW+1)'(prod_b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qi_reg  <= in_data.index_i;
            qj_reg  <= in_data.index_j;
            rng_reg <= in_rng;
            fi_reg  <= (in_data.index_i == 6'd0);
            li_reg  <= (LW'(in_data.index_i) == ci - LW'(1));
            fj_reg  <= (in_data.index_j == 6'd0);
            lj_reg  <= (LW'(in_data.index_j) == cj - LW'(1));
        end
        if (cmd.cap)
        begin
            vx_reg[cmd.cap_slot] <= rdx_reg;
            vy_reg[cmd.cap_slot] <= rdy_reg;
        end
        if (cmd.deriv)
        begin
            kx_reg <= twice(vx_reg[0], vx_reg[1], vx_reg[2], fi_reg, li_reg);
            ky_reg <= twice(vy_reg[0], vy_reg[1], vy_reg[2], fi_reg, li_reg);
            ex_reg <= twice(vx_reg[0], vx_reg[3], vx_reg[4], fj_reg, lj_reg);
            ey_reg <= twice(vy_reg[0], vy_reg[3], vy_reg[4], fj_reg, lj_reg);
        end
        if (cmd.mul_a)
            prod_a_reg <= mul_p;
        if (cmd.mul_b)
            prod_b_reg <= mul_p;
        if (cmd.prep)
        begin
            pneg_reg <= p_full[PW];
            pmag_reg <= p_full[PW] ? PW'(-p_full) : PW'(p_full);
        end
        if (cmd.div_init)
        begin
            rem_reg <= num;
            dsh_reg <= RW'(pmag_reg) << 32;
            ovf_reg <= (num >= (RW'(pmag_reg) << 33));
            quo_reg <= '0;
            neg_reg <= nneg ^ pneg_reg;
        end
        if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[31:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[31:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.div_end)
            res_reg[cmd.met] <= sat(quo_reg, neg_reg, ovf_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sing_reg <= 1'b1;
        else if (cmd.load)
            sing_reg <= !in_rng;
        else if (cmd.prep)
            sing_reg <= (prod_a_reg == prod_b_reg);
    end

    // output register: the next item may start while a result waits here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (sing_reg)
            begin
                out_data_reg          <= '0;
                out_data_reg.singular <= 1'b1;
            end
            else
            begin
                out_data_reg.ksi_x        <= res_reg[MET_KSI_X];
                out_data_reg.ksi_y        <= res_reg[MET_KSI_Y];
                out_data_reg.eta_x        <= res_reg[MET_ETA_X];
                out_data_reg.eta_y        <= res_reg[MET_ETA_Y];
                out_data_reg.inv_jacobian <= res_reg[MET_INV_J];
                out_data_reg.singular     <= 1'b0;
            end
        end
    end

    assign status.in_range = rng_reg;
    assign status.p_zero   = (prod_a_reg == prod_b_reg);
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hdl/grid_metric_coefficients.sv =====
// top level of the grid metric block
// A store beat writes one grid point and the block is ready again in the
// next cycle. A query beat runs one point at a time: reads of the coordinate
// memories (centre plus two neighbours along each direction), the
// differences, two products through the shared 36x36 multiplier, the
// determinant, then five restoring divisions on the one shared divider (one
// quotient bit a cycle), and a load into the output register once it is free.
// A zero determinant skips the divisions, and a query outside the grid goes
// from the reads straight to the output register. The next item is taken
// while a result still waits in the output register. Write the counts only
// while the block is idle; the coordinate memories are not cleared.
module grid_metric_coefficients #(
    parameter int MAX_I = gmc_pkg::MAX_I_DEF,
    parameter int MAX_J = gmc_pkg::MAX_J_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  gmc_pkg::in_item_t         in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output gmc_pkg::out_item_t        out_data,
    input  logic                      cfg_write,
    input  logic                      cfg_index,
    input  logic [gmc_pkg::CFG_W-1:0] cfg_data
);
    import gmc_pkg::*;

    cmd_t    cmd;
    status_t status;

    gmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_data.op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gmc_datapath #(
        .MAX_I (MAX_I),
        .MAX_J (MAX_J)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/gmc_checker.sv =====
// port-level checks of the grid metric block and their bind
`include "grid_metric_coefficients_macros.svh"

module gmc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input gmc_pkg::in_item_t         in_data,
    input logic                      out_valid,
    input logic                      out_stall,
    input gmc_pkg::out_item_t        out_data,
    input logic                      cfg_write,
    input logic                      cfg_index,
    input logic [gmc_pkg::CFG_W-1:0] cfg_data
);
    import gmc_pkg::*;

    `GMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
    `GMC_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && in_data.op == OP_QUERY, in_stall, "input taken during a query")
    `GMC_ASSERT_NEXT(a_store_free, in_valid && !in_stall && in_data.op == OP_STORE, !in_stall, "store did not free the input")
    `GMC_ASSERT_SAME(a_sing_zero, out_valid && out_data.singular, out_data.ksi_x == 0 && out_data.ksi_y == 0 && out_data.eta_x == 0 && out_data.eta_y == 0 && out_data.inv_jacobian == 0, "singular result with nonzero metrics")

endmodule

bind grid_metric_coefficients gmc_checker u_gmc_checker (.*);

// ===== sim/testbench.sv =====
// self-checking testbench for the grid metric block
module testbench;
    import gmc_pkg::*;

    localparam int GRID_J = MAX_J_DEF;
    localparam int MEM_DEPTH = MAX_I_DEF * MAX_J_DEF;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_write;
    logic cfg_index;
    logic [CFG_W-1:0] cfg_data;

    grid_metric_coefficients dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor copy of the grid and the counts
    logic signed [31:0] coord_x_mem [MEM_DEPTH];
    logic signed [31:0] coord_y_mem [MEM_DEPTH];
    bit written_mem [MEM_DEPTH];
    logic [CFG_W-1:0] count_i_reg;
    logic [CFG_W-1:0] count_j_reg;

    out_item_t pending_metrics [$];
    int fail_count;
    int burst_left;

    // shape of the grid produced for stencil fills
    int step_a;
    int step_b;
    int shear;
    int noise_max;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_count(logic [CFG_W-1:0] c);
        if (c < 3)
            return 3;
        if (c > 64)
            return 64;
        return int'(c);
    endfunction

    function automatic logic signed [63:0] grid_val(bit is_y, int i, int j);
        logic signed [31:0] v;
        v = is_y ? coord_y_mem[i * GRID_J + j] : coord_x_mem[i * GRID_J + j];
        return 64'(v);
    endfunction

    // twice the first derivative along one direction, raw Q16.16 units
    function automatic logic signed [63:0] twice_slope(bit is_y, int i, int j, bit along_i);
        int pos;
        int cnt;
        int di;
        int dj;
        pos = along_i ? i : j;
        cnt = along_i ? eff_count(count_i_reg) : eff_count(count_j_reg);
        di = along_i ? 1 : 0;
        dj = along_i ? 0 : 1;
        if (pos == 0)
            return 4 * grid_val(is_y, i + di, j + dj) - grid_val(is_y, i + 2*di, j + 2*dj)
                   - 3 * grid_val(is_y, i, j);
        if (pos == cnt - 1)
            return 3 * grid_val(is_y, i, j) - 4 * grid_val(is_y, i - di, j - dj)
                   + grid_val(is_y, i - 2*di, j - 2*dj);
        return grid_val(is_y, i + di, j + dj) - grid_val(is_y, i - di, j - dj);
    endfunction

    function automatic logic [31:0] sat_quotient(logic [127:0] num, bit neg, logic [127:0] den);
        logic [127:0] q;
        q = num / den;
        if (!neg)
            return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        return (q > 128'h8000_0000) ? 32'h8000_0000 : 32'(0) - q[31:0];
    endfunction

    function automatic logic [31:0] metric_term(logic signed [63:0] d, bit flip,
                                                logic [127:0] pmag, bit pneg);
        logic [127:0] num;
        num = 128'(d < 0 ? -d : d) << 33;
        return sat_quotient(num, ((d < 0) != flip) != pneg, pmag);
    endfunction

    function automatic out_item_t metric_terms(int i, int j);
        out_item_t r;
        logic signed [63:0] kx, ky, ex, ey;
        logic signed [127:0] a, b, c, d, p;
        logic [127:0] pmag;
        bit pneg;
        r = '0;
        r.singular = 1'b1;
        if (i >= eff_count(count_i_reg) || j >= eff_count(count_j_reg))
            return r;
        kx = twice_slope(1'b0, i, j, 1'b1);
        ky = twice_slope(1'b1, i, j, 1'b1);
        ex = twice_slope(1'b0, i, j, 1'b0);
        ey = twice_slope(1'b1, i, j, 1'b0);
        a = kx;
        b = ey;
        c = ex;
        d = ky;
        p = a * b - c * d;
        if (p == 0)
            return r;
        pneg = p < 0;
        pmag = pneg ? -p : p;
        r.ksi_x = metric_term(ey, 1'b0, pmag, pneg);
        r.ksi_y = metric_term(ex, 1'b1, pmag, pneg);
        r.eta_x = metric_term(ky, 1'b1, pmag, pneg);
        r.eta_y = metric_term(kx, 1'b0, pmag, pneg);
        r.inv_jacobian = sat_quotient(128'(1) << 50, pneg, pmag);
        r.singular = 1'b0;
        return r;
    endfunction

    // stimulus side: one beat, bursts with random gaps
    task automatic send_item(in_item_t item);
        int i;
        int j;
        @(negedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        i = item.index_i;
        j = item.index_j;
        if (item.op == OP_STORE)
        begin
            if (i < eff_count(count_i_reg) && j < eff_count(count_j_reg))
            begin
                coord_x_mem[i * GRID_J + j] = item.coord_x;
                coord_y_mem[i * GRID_J + j] = item.coord_y;
                written_mem[i * GRID_J + j] = 1'b1;
            end
        end
        else
            pending_metrics = {pending_metrics, metric_terms(i, j)};
    endtask

    task automatic store_point(int i, int j, logic [31:0] x, logic [31:0] y);
        in_item_t item;
        item.op = OP_STORE;
        item.index_i = 6'(i);
        item.index_j = 6'(j);
        item.coord_x = x;
        item.coord_y = y;
        send_item(item);
    endtask

    task automatic query_point(int i, int j);
        in_item_t item;
        item.op = OP_QUERY;
        item.index_i = 6'(i);
        item.index_j = 6'(j);
        item.coord_x = $urandom;
        item.coord_y = $urandom;
        send_item(item);
    endtask

    task automatic store_shaped(int i, int j);
        int pick;
        logic [31:0] x;
        logic [31:0] y;
        pick = $urandom_range(0, 99);
        if (pick < 85)
        begin
            x = i * step_a + j * shear + $urandom_range(0, noise_max);
            y = j * step_b - i * shear + $urandom_range(0, noise_max);
        end
        else if (pick < 95)
        begin
            x = $urandom;
            y = $urandom;
        end
        else
        begin
            x = '0;
            y = '0;
        end
        store_point(i, j, x, y);
    endtask

    // write every stencil entry of (i,j) not yet written
    task automatic fill_stencil(int i, int j);
        int ci;
        int cj;
        int lo_i;
        int lo_j;
        ci = eff_count(count_i_reg);
        cj = eff_count(count_j_reg);
        if (i >= ci || j >= cj)
            return;
        lo_i = (i == 0) ? 0 : (i == ci - 1) ? i - 2 : i - 1;
        lo_j = (j == 0) ? 0 : (j == cj - 1) ? j - 2 : j - 1;
        for (int k = lo_i; k < lo_i + 3; k++)
            if (!written_mem[k * GRID_J + j])
                store_shaped(k, j);
        for (int k = lo_j; k < lo_j + 3; k++)
            if (!written_mem[i * GRID_J + k])
                store_shaped(i, k);
    endtask

    // counts change only once the block has drained
    task automatic wait_idle;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_metrics.size() != 0)
            @(posedge clk);
        repeat (220) @(posedge clk);
    endtask

    task automatic write_count(logic idx, logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == REG_COUNT_I)
            count_i_reg = value;
        else
            count_j_reg = value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic new_grid_shape;
        step_a = $urandom_range(1 << 10, 1 << 20);
        step_b = $urandom_range(1 << 10, 1 << 20);
        shear = $urandom_range(0, 1 << 14);
        noise_max = $urandom_range(0, 1 << 12);
    endtask

    // three by three grid: singular, unit spacing, extreme coordinates, queries outside the grid
    task automatic test_small_grid;
        write_count(REG_COUNT_I, 7'd3);
        write_count(REG_COUNT_J, 7'd3);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                store_point(i, j, '0, '0);
        query_point(1, 1);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                store_point(i, j, i << 16, j << 16);
        query_point(0, 0);
        query_point(2, 1);
        query_point(1, 2);
        query_point(1, 1);
        store_point(0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        store_point(2, 2, 32'h8000_0000, 32'h7FFF_FFFF);
        query_point(0, 0);
        query_point(2, 2);
        store_point(1, 0, 32'h0000_0001, 32'h0000_0000);
        query_point(0, 0);
        store_point(5, 5, 32'h1234_5678, 32'h8765_4321);
        query_point(3, 0);
        query_point(63, 63);
    endtask

    // counts below and above the legal range act as the limits
    task automatic test_count_limits;
        write_count(REG_COUNT_I, 7'd0);
        write_count(REG_COUNT_J, 7'd127);
        fill_stencil(2, 63);
        query_point(2, 63);
        query_point(3, 10);
        write_count(REG_COUNT_I, 7'd65);
        write_count(REG_COUNT_J, 7'd2);
        fill_stencil(63, 2);
        query_point(63, 2);
        query_point(0, 0);
        query_point(10, 3);
    endtask

    task automatic test_random(int n);
        int ci;
        int cj;
        int i;
        int j;
        new_grid_shape();
        ci = eff_count(count_i_reg);
        cj = eff_count(count_j_reg);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                i = $urandom_range(0, 63);
                j = $urandom_range(0, 63);
            end
            else
            begin
                i = $urandom_range(0, ci - 1);
                j = $urandom_range(0, cj - 1);
            end
            if ($urandom_range(0, 99) < 55)
            begin
                fill_stencil(i, j);
                query_point(i, j);
            end
            else
                store_shaped(i, j);
        end
    endtask

    task automatic test_random_phases;
        test_random(100);
        write_count(REG_COUNT_I, 7'd64);
        write_count(REG_COUNT_J, 7'd64);
        test_random(100);
        write_count(REG_COUNT_I, 7'd1);
        write_count(REG_COUNT_J, 7'd3);
        test_random(80);
        write_count(REG_COUNT_I, 7'($urandom_range(4, 30)));
        write_count(REG_COUNT_J, 7'($urandom_range(4, 30)));
        test_random(100);
    endtask

    // receiver stalls in runs, with quiet stretches
    initial
    begin
        int run;
        out_stall = 1'b0;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                case ($urandom_range(0, 3))
                    0: begin out_stall <= 1'b0; run = $urandom_range(100, 400); end
                    1: begin out_stall <= 1'b1; run = $urandom_range(1, 20); end
                    default: begin out_stall <= $urandom_range(0, 1); run = 1; end
                endcase
            end
            else
                run--;
        end
    end

    task automatic check_field(string name, logic [31:0] expd, logic [31:0] got);
        if (expd !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expd, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t expd;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_metrics.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %h", $time, out_data);
                fail_count++;
            end
            else
            begin
                expd = pending_metrics.pop_front();
                check_field("ksi_x", expd.ksi_x, out_data.ksi_x);
                check_field("ksi_y", expd.ksi_y, out_data.ksi_y);
                check_field("eta_x", expd.eta_x, out_data.eta_x);
                check_field("eta_y", expd.eta_y, out_data.eta_y);
                check_field("inv_jacobian", expd.inv_jacobian, out_data.inv_jacobian);
                check_field("singular", 32'(expd.singular), 32'(out_data.singular));
            end
        end
    end

    initial
    begin
        int drain;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = REG_COUNT_I;
        cfg_data = '0;
        fail_count = 0;
        burst_left = 0;
        count_i_reg = COUNT_RESET;
        count_j_reg = COUNT_RESET;
        for (int k = 0; k < MEM_DEPTH; k++)
            written_mem[k] = 1'b0;
        new_grid_shape();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_small_grid();
        test_count_limits();
        test_random_phases();

        @(negedge clk);
        in_valid <= 1'b0;
        drain = 0;
        while (pending_metrics.size() != 0 && drain < 2000000)
        begin
            @(posedge clk);
            drain++;
        end
        if (pending_metrics.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_metrics.size());
            fail_count++;
        end
        repeat (220) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
